### rtl/spss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper sequencer package
// Shared transaction types, command and register codes for the step sequencer.
// ----------------------------------------------------------------------------
package spss_pkg;

   // Field widths.
   localparam int KIND_W   = 3;
   localparam int COUNT_W  = 32;
   localparam int POS_W    = 24;
   localparam int PERIOD_W = 32;
   localparam int SPR_W    = 16;
   localparam int MODE_W   = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MODE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR    = 2'd2;

   localparam logic [SPR_W-1:0]  SPR_RESET      = 16'd200;
   localparam logic [MODE_W-1:0] MODE_MICROSTEP = 2'd3;

   // Command kinds.
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RUN       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RUN_COUNT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GOTO      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STOP      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ORIGIN    = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic                direction;
      logic [COUNT_W-1:0]  step_count;
      logic [POS_W-1:0]    target_step;
      logic [PERIOD_W-1:0] step_period_us;
   } req_type;

   typedef struct packed {
      logic              step_pulse;
      logic              coil_direction;
      logic [MODE_W-1:0] step_style;
      logic [POS_W-1:0]  position;
      logic              turning;
   } rsp_type;

   // Live configuration with the derived revolution size.
   typedef struct packed {
      logic [MODE_W-1:0] step_mode;
      logic              coil_swap;
      logic [POS_W-1:0]  total;
   } cfg_type;

   // Remainder unit control and status.
   typedef struct packed {
      logic             start;
      logic             clear;
      logic [POS_W-1:0] dividend;
      logic [POS_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [POS_W-1:0] rem;
   } mod_rsp_type;

endpackage

### rtl/spss_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper sequencer configuration registers
// Holds the revolution size, step mode and inversion, and derives the number
// of positions in one revolution.
// ----------------------------------------------------------------------------
module spss_csr #(
   parameter int MICROSTEP_FACTOR = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [spss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output spss_pkg::cfg_type                   cfg
);
   import spss_pkg::*;

   logic [SPR_W-1:0]  spr_ff;
   logic [MODE_W-1:0] mode_ff;
   logic              invert_ff;
   logic [SPR_W-1:0]  spr_base;
   logic [POS_W-1:0]  base_wide;

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff    <= SPR_RESET;
         mode_ff   <= '0;
         invert_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEPS_PER_REV: spr_ff    <= csr_wdata[SPR_W-1:0];
            CSR_STEP_MODE:     mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_INVERT_DIR:    invert_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // A zero revolution counts as one; microstepping multiplies it.
   always_comb begin
      spr_base  = (spr_ff == '0) ? SPR_W'(1) : spr_ff;
      base_wide = {{(POS_W-SPR_W){1'b0}}, spr_base};
      cfg.step_mode = mode_ff;
      cfg.coil_swap = invert_ff;
      if (mode_ff == MODE_MICROSTEP) begin
         cfg.total = base_wide * POS_W'(MICROSTEP_FACTOR);
      end else begin
         cfg.total = base_wide;
      end
   end

endmodule

### rtl/spss_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper sequencer remainder unit
// Restoring remainder of the position by the revolution size, one bit a cycle.
// ----------------------------------------------------------------------------
module spss_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  spss_pkg::mod_req_type mod_req,
   output spss_pkg::mod_rsp_type mod_rsp
);
   import spss_pkg::*;

   localparam int CNT_W = $clog2(POS_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0] dvd_ff, dvd_in;
   logic [POS_W-1:0] div_ff, div_in;
   logic [POS_W:0]   trial;

   // One shift and conditional subtract per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      trial   = {rem_ff, dvd_ff[POS_W-1]};
      if (mod_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = POS_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[POS_W-1:0];
         end
         dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (mod_req.clear) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign mod_rsp.busy = busy_ff;
   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

endmodule

### rtl/spss_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper sequencer core
// Run state, position and tick timing; works out the result of one transaction.
// ----------------------------------------------------------------------------
module spss_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic                  fire,
   input  spss_pkg::req_type     item,
   input  spss_pkg::cfg_type     cfg,
   input  spss_pkg::mod_rsp_type mod_rsp,
   output spss_pkg::mod_req_type mod_req,
   output logic                  item_ready,
   output spss_pkg::rsp_type     result
);
   import spss_pkg::*;

   logic [POS_W-1:0]    position_ff, position_in;
   logic [COUNT_W-1:0]  remaining_ff, remaining_in;
   logic                running_ff, running_in;
   logic                lrev_ff, lrev_in;
   logic                pback_ff, pback_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   logic                pulse;
   logic                pos_in_range;
   logic [POS_W-1:0]    last;
   logic [POS_W-1:0]    fwd_pos;
   logic [POS_W-1:0]    rev_pos;
   logic [POS_W-1:0]    here;
   logic [POS_W-1:0]    tgt;
   logic [POS_W:0]      travel;
   logic [PERIOD_W-1:0] elapsed_next;
   logic [COUNT_W-1:0]  run_count;
   logic                start_run;
   logic                do_halt;

   assign pos_in_range = position_ff < cfg.total;
   assign last         = cfg.total - POS_W'(1);

   // A go-to from a position beyond the revolution waits for the remainder.
   assign item_ready = (item.kind != KIND_GOTO) || pos_in_range || mod_rsp.done;

   assign mod_req.start    = item_valid && (item.kind == KIND_GOTO) && !pos_in_range
                             && !mod_rsp.busy && !mod_rsp.done;
   assign mod_req.clear    = fire;
   assign mod_req.dividend = position_ff;
   assign mod_req.divisor  = cfg.total;

   // Neighbouring positions with wrap at either end of the revolution.
   always_comb begin
      fwd_pos = (position_ff >= last) ? '0 : position_ff + POS_W'(1);
      if ((position_ff == '0) || !pos_in_range) begin
         rev_pos = last;
      end else begin
         rev_pos = position_ff - POS_W'(1);
      end
      elapsed_next = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + PERIOD_W'(1);
   end

   // Go-to distance measured in the requested direction.
   always_comb begin
      here = pos_in_range ? position_ff : mod_rsp.rem;
      tgt  = (item.target_step >= cfg.total) ? last : item.target_step;
      if (!item.direction) begin
         if (here > tgt) begin
            travel = {1'b0, tgt} + {1'b0, cfg.total} - {1'b0, here};
         end else begin
            travel = {1'b0, tgt} - {1'b0, here};
         end
      end else begin
         if (here >= tgt) begin
            travel = {1'b0, here} - {1'b0, tgt};
         end else begin
            travel = {1'b0, here} + {1'b0, cfg.total} - {1'b0, tgt};
         end
      end
   end

   // Next state for the transaction in hand.
   always_comb begin
      position_in  = position_ff;
      remaining_in = remaining_ff;
      running_in   = running_ff;
      lrev_in      = lrev_ff;
      pback_in     = pback_ff;
      elapsed_in   = elapsed_ff;
      period_in    = period_ff;
      pulse        = 1'b0;
      start_run    = 1'b0;
      do_halt      = 1'b0;
      run_count    = '0;

      case (item.kind)
         KIND_TICK: begin
            if (running_ff) begin
               if (elapsed_next < period_ff) begin
                  elapsed_in = elapsed_next;
               end else begin
                  elapsed_in  = '0;
                  pulse       = 1'b1;
                  position_in = lrev_ff ? rev_pos : fwd_pos;
                  if (remaining_ff != '0) begin
                     remaining_in = remaining_ff - COUNT_W'(1);
                     if (remaining_ff == COUNT_W'(1)) begin
                        running_in = 1'b0;
                     end
                  end
               end
            end
         end
         KIND_RUN: begin
            start_run = 1'b1;
         end
         KIND_RUN_COUNT: begin
            run_count = item.step_count;
            start_run = (item.step_count != '0);
            do_halt   = (item.step_count == '0);
         end
         KIND_GOTO: begin
            run_count = {{(COUNT_W-POS_W-1){1'b0}}, travel};
            start_run = (travel != '0);
            do_halt   = (travel == '0);
         end
         KIND_STOP: begin
            do_halt = 1'b1;
         end
         KIND_ORIGIN: begin
            position_in = '0;
         end
         default: begin
         end
      endcase

      // Starting a run latches direction with the inversion now in force.
      if (start_run) begin
         remaining_in = run_count;
         period_in    = item.step_period_us;
         lrev_in      = item.direction;
         pback_in     = item.direction ^ cfg.coil_swap;
         elapsed_in   = '0;
         running_in   = 1'b1;
      end
      if (do_halt) begin
         running_in   = 1'b0;
         remaining_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         remaining_ff <= '0;
         running_ff   <= 1'b0;
         lrev_ff      <= 1'b0;
         pback_ff     <= 1'b0;
         elapsed_ff   <= '0;
         period_ff    <= '0;
      end else if (fire) begin
         position_ff  <= position_in;
         remaining_ff <= remaining_in;
         running_ff   <= running_in;
         lrev_ff      <= lrev_in;
         pback_ff     <= pback_in;
         elapsed_ff   <= elapsed_in;
         period_ff    <= period_in;
      end
   end

   // Result fields as seen after this transaction.
   assign result.step_pulse     = pulse;
   assign result.coil_direction = pback_in;
   assign result.step_style     = cfg.step_mode;
   assign result.position       = position_in;
   assign result.turning        = running_in;

endmodule

### rtl/stepper_position_step_sequencer.sv
`timescale 1ns / 1ps
// A transaction waits in the input register until the core is ready and the
// result slot is free, then its result is held in the result register.
// Throughput: one transaction per cycle without stalls; a go-to issued while the
// position is beyond the revolution waits for the bit-serial remainder unit.
// Reset: synchronous, active high; registers return to 200 steps, step mode 0,
// no inversion, and all run state and the position clear to zero.
// ----------------------------------------------------------------------------
// Stepper step and position sequencer
// Input register, single-pass core update and result register, with the
// configuration registers and a remainder unit for go-to commands.
// ----------------------------------------------------------------------------
module stepper_position_step_sequencer #(
   parameter int MICROSTEP_FACTOR = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  spss_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output spss_pkg::rsp_type               rsp_data,
   input  logic                            csr_write,
   input  logic [spss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spss_pkg::*;

   cfg_type     cfg;
   mod_req_type mod_req;
   mod_rsp_type mod_rsp;
   rsp_type     result;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    item_ready;
   logic    fire;
   logic    take;

   spss_csr #(
      .MICROSTEP_FACTOR(MICROSTEP_FACTOR)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spss_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   spss_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .fire       (fire),
      .item       (in_data_ff),
      .cfg        (cfg),
      .mod_rsp    (mod_rsp),
      .mod_req    (mod_req),
      .item_ready (item_ready),
      .result     (result)
   );

   // The held transaction moves on when the core is ready and the result slot frees.
   assign fire      = in_valid_ff && item_ready && (!out_valid_ff || !rsp_stall);
   assign take      = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !fire;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // The remainder unit only runs for a go-to held in the input register.
   a_mod_for_goto: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.busy |-> (in_valid_ff && (in_data_ff.kind == KIND_GOTO)))
      else $error("remainder unit busy without a pending go-to");

   // No transaction passes the core while the remainder is being worked out.
   a_no_fire_busy: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.busy |-> !fire)
      else $error("transaction processed during remainder computation");

   // Only a tick can issue a step pulse.
   a_pulse_tick: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_data_ff.kind != KIND_TICK)) |=> !rsp_data.step_pulse)
      else $error("step pulse issued for a command");
`endif

endmodule
